// ===== rtl/fpd_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the frame deframer.
// No dependencies; every other file of the block uses it by scoped names.
package fpd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [BYTE_W-1:0] SYNC_RESET    = 8'hAA;
  localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd250;
  localparam logic [BYTE_W-1:0] CRC_POLY      = 8'h07;
  localparam logic [POS_W-1:0]  HEADER_BYTES  = 9'd5;
  localparam logic [POS_W-1:0]  POS_LEN_HI    = 9'd3;
  localparam logic [POS_W-1:0]  POS_LEN_LO    = 9'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN    = 8'd1;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CRC
  } phase_t;

  typedef enum logic [2:0] {
    KIND_DISCARD = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_GOOD    = 3'd3,
    KIND_BAD     = 3'd4,
    KIND_ABORT   = 3'd5
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_value;
    logic [BYTE_W-1:0] max_payload_len;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    kind_t             kind;
    logic [BYTE_W-1:0] frame_index;
    logic [LEN_W-1:0]  declared_len;
  } result_t;

  // One byte through the CRC-8 shift register, MSB first.
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/fpd_rx_if.sv =====
// Byte stream channel into the deframer: valid, ready and the received byte.
// Depends on fpd_pkg for the byte width.
interface fpd_rx_if;
  logic                       valid;
  logic                       ready;
  logic [fpd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/fpd_res_if.sv =====
// Result channel out of the deframer: valid, ready and one tagged byte.
// Depends on fpd_pkg for the field widths.
interface fpd_res_if;
  logic                       valid;
  logic                       ready;
  logic [fpd_pkg::BYTE_W-1:0] data_byte;
  logic [2:0]                 byte_kind;
  logic [fpd_pkg::BYTE_W-1:0] frame_index;
  logic [fpd_pkg::LEN_W-1:0]  declared_len;

  modport source (output valid, output data_byte, output byte_kind, output frame_index,
                  output declared_len, input ready);
  modport sink   (input valid, input data_byte, input byte_kind, input frame_index,
                  input declared_len, output ready);
endinterface

// ===== rtl/fpd_cfg_if.sv =====
// Configuration write channel: valid, ready, register index and write data.
// Depends on fpd_pkg for the index and data widths.
interface fpd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fpd_pkg::CFG_IDX_W-1:0]  index;
  logic [fpd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/fpd_cfg_regs.sv =====
// Configuration registers of the deframer (sync byte value, payload limit).
// Depends on fpd_pkg and fpd_cfg_if.
module fpd_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  fpd_cfg_if.sink          cfg_ch,
  output fpd_pkg::cfg_t    cfg
);

  fpd_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_value      <= fpd_pkg::SYNC_RESET;
      cfg_r.max_payload_len <= fpd_pkg::MAX_LEN_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == fpd_pkg::REG_SYNC_VALUE) begin
        cfg_r.sync_value <= cfg_ch.data;
      end
      if (cfg_ch.index == fpd_pkg::REG_MAX_LEN) begin
        cfg_r.max_payload_len <= cfg_ch.data;
      end
    end
  end

endmodule

// ===== rtl/fpd_parser.sv =====
// Frame state machine: phase, byte position, length and running CRC-8, plus
// the classification of the registered byte. Depends on fpd_pkg.
module fpd_parser (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic [fpd_pkg::BYTE_W-1:0] rx_byte,
  input  fpd_pkg::cfg_t              cfg,
  output fpd_pkg::result_t           res
);

  fpd_pkg::phase_t             phase_r, phase_nxt;
  logic [fpd_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [fpd_pkg::LEN_W-1:0]   plen_r, plen_nxt;
  logic [fpd_pkg::BYTE_W-1:0]  crc_r, crc_nxt;

  logic [fpd_pkg::BYTE_W-1:0]  crc_fed;
  logic [fpd_pkg::LEN_W-1:0]   full_len;
  logic [fpd_pkg::POS_W-1:0]   pos_inc;
  logic [fpd_pkg::LEN_W:0]     payload_end;

  assign crc_fed     = fpd_pkg::crc8_byte(crc_r, rx_byte);
  assign full_len    = {plen_r[fpd_pkg::LEN_W-1:fpd_pkg::BYTE_W], rx_byte};
  assign pos_inc     = pos_r + 1'b1;
  assign payload_end = {1'b0, plen_r} + {{(fpd_pkg::LEN_W + 1 - fpd_pkg::POS_W){1'b0}},
                                         fpd_pkg::HEADER_BYTES};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fpd_pkg::PH_HUNT;
      pos_r   <= '0;
      plen_r  <= '0;
      crc_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      plen_r  <= plen_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    pos_nxt          = pos_r;
    plen_nxt         = plen_r;
    crc_nxt          = crc_r;
    res.data_byte    = rx_byte;
    res.kind         = fpd_pkg::KIND_DISCARD;
    res.frame_index  = '0;
    res.declared_len = '0;
    case (phase_r)
      fpd_pkg::PH_HUNT: begin
        if (rx_byte == cfg.sync_value) begin
          res.kind  = fpd_pkg::KIND_HEADER;
          crc_nxt   = fpd_pkg::crc8_byte('0, rx_byte);
          plen_nxt  = '0;
          pos_nxt   = {{(fpd_pkg::POS_W-1){1'b0}}, 1'b1};
          phase_nxt = fpd_pkg::PH_HEADER;
        end
      end
      fpd_pkg::PH_HEADER: begin
        res.frame_index = pos_r[fpd_pkg::BYTE_W-1:0];
        res.kind        = fpd_pkg::KIND_HEADER;
        crc_nxt         = crc_fed;
        if (pos_r == fpd_pkg::POS_LEN_HI) begin
          plen_nxt = {rx_byte, {fpd_pkg::BYTE_W{1'b0}}};
          pos_nxt  = fpd_pkg::POS_LEN_LO;
        end else if (pos_r == fpd_pkg::POS_LEN_LO) begin
          res.declared_len = full_len;
          if (full_len > {{(fpd_pkg::LEN_W-fpd_pkg::BYTE_W){1'b0}}, cfg.max_payload_len}) begin
            res.kind  = fpd_pkg::KIND_ABORT;
            phase_nxt = fpd_pkg::PH_HUNT;
            pos_nxt   = '0;
            plen_nxt  = '0;
            crc_nxt   = '0;
          end else begin
            plen_nxt  = full_len;
            pos_nxt   = fpd_pkg::HEADER_BYTES;
            phase_nxt = (full_len == '0) ? fpd_pkg::PH_CRC : fpd_pkg::PH_PAYLOAD;
          end
        end else begin
          pos_nxt = pos_inc;
        end
      end
      fpd_pkg::PH_PAYLOAD: begin
        res.frame_index  = pos_r[fpd_pkg::BYTE_W-1:0];
        res.declared_len = plen_r;
        res.kind         = fpd_pkg::KIND_PAYLOAD;
        crc_nxt          = crc_fed;
        pos_nxt          = pos_inc;
        if ({{(fpd_pkg::LEN_W + 1 - fpd_pkg::POS_W){1'b0}}, pos_inc} >= payload_end) begin
          phase_nxt = fpd_pkg::PH_CRC;
        end
      end
      fpd_pkg::PH_CRC: begin
        res.frame_index  = pos_r[fpd_pkg::BYTE_W-1:0];
        res.declared_len = plen_r;
        res.kind         = (rx_byte == crc_r) ? fpd_pkg::KIND_GOOD : fpd_pkg::KIND_BAD;
        phase_nxt        = fpd_pkg::PH_HUNT;
        pos_nxt          = '0;
        plen_nxt         = '0;
        crc_nxt          = '0;
      end
      default: begin
        phase_nxt = fpd_pkg::PH_HUNT;
        pos_nxt   = '0;
        plen_nxt  = '0;
        crc_nxt   = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  // While hunting, all frame state is back at its cleared value.
  a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == fpd_pkg::PH_HUNT |-> pos_r == '0 && plen_r == '0 && crc_r == '0)
    else $error("frame state not cleared while hunting");

  // A payload phase only follows a complete, nonzero header length.
  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == fpd_pkg::PH_PAYLOAD |-> plen_r != '0 && pos_r >= fpd_pkg::HEADER_BYTES)
    else $error("payload phase without a valid header");

  // The CRC byte closes the frame and hunting resumes.
  a_crc_ends: assert property (@(posedge clk) disable iff (!rst_n)
    advance && phase_r == fpd_pkg::PH_CRC |=> phase_r == fpd_pkg::PH_HUNT)
    else $error("frame did not end after the CRC byte");
`endif

endmodule

// ===== rtl/framed_packet_crc8_deframer.sv =====
// Path: a byte accepted into the byte register is classified into the result register, which drives the output.
// Throughput: one byte per clock while the output is ready; the byte register and the result register
// let the input take a new transaction while a result waits on the output.
// The whole classification and CRC-8 update sit between those two registers.
// Reset: synchronous, active low; clears both valids, the frame state and
// loads sync_value 0xAA and max_payload_len 250.
module framed_packet_crc8_deframer (
  input  logic    clk,
  input  logic    rst_n,
  fpd_rx_if.sink  in_ch,
  fpd_res_if.source out_ch,
  fpd_cfg_if.sink cfg_ch
);

  // Input register: one byte waiting to be classified.
  logic                       in_valid_r;
  logic [fpd_pkg::BYTE_W-1:0] byte_r;

  // Result register: one classified byte waiting to be taken.
  logic                       out_valid_r;
  fpd_pkg::result_t           result_r;

  fpd_pkg::cfg_t              cfg;
  fpd_pkg::result_t           res;
  logic                       out_free;
  logic                       advance;

  // The byte register moves forward when the result register is empty or
  // is being emptied in this cycle; the frame state updates at that edge.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign advance     = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || advance;

  fpd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  fpd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .rx_byte (byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  // The byte itself is payload and needs no reset.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.data_byte    = result_r.data_byte;
  assign out_ch.byte_kind    = result_r.kind;
  assign out_ch.frame_index  = result_r.frame_index;
  assign out_ch.declared_len = result_r.declared_len;

`ifndef SYNTHESIS
  // Reset empties both registers.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !in_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  // Every byte that moves forward produces a result in the next cycle.
  a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("classified byte lost");

  // A discarded byte carries no frame position and no length.
  a_discard_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.kind == fpd_pkg::KIND_DISCARD
      |-> result_r.frame_index == '0 && result_r.declared_len == '0)
    else $error("discarded byte with frame fields set");
`endif

endmodule
